>>> design/tpps_pkg.sv
// Package for the triangular point path smoother.
// Holds field widths, reset values and the command and status structs
// that join the controller and the datapath. No dependencies.
package tpps_pkg;

  localparam int COORD_W  = 10;
  localparam int HALF_W   = 3;
  localparam int SEEN_W   = 4;
  localparam int MAX_HALF = 7;

  localparam logic [SEEN_W-1:0] SEEN_MAX   = 4'd15;
  localparam logic [HALF_W-1:0] HALF_RESET = 3'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic win_fill;   // load the accepted point into every window entry
    logic win_shift;  // shift the accepted point into the window
    logic win_dup;    // shift the newest entry in again (end of path)
    logic acc_start;  // clear the accumulators and the tap counter
    logic acc_run;    // add one weighted tap
    logic div_run;    // one quotient bit
    logic out_load;   // move the quotient into the output register
    logic last;       // final flag for the word being loaded
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_done;   // the current tap is the last one
    logic div_done;   // the current quotient bit is the last one
    logic out_free;   // the output register can take a word this cycle
  } sts_t;

endpackage

>>> design/tpps_ctrl.sv
// Controller of the triangular point path smoother.
// Sequences window update, accumulation, division and output per point.
// Depends on tpps_pkg.
module tpps_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tpps_pkg::HALF_W-1:0]   half_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          end_of_path_i,
  output tpps_pkg::cmd_t                cmd_o,
  input  tpps_pkg::sts_t                sts_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_PUT   = 6'b010000,
    ST_NEXT  = 6'b100000
  } state_e;

  localparam int CntW = tpps_pkg::SEEN_W + 1;

  state_e                        state_q, state_d;
  logic [tpps_pkg::SEEN_W-1:0]   seen_q, seen_d;
  logic [tpps_pkg::HALF_W-1:0]   k_q, k_d;
  logic                          eop_q, eop_d;
  logic                          last_q, last_d;
  logic                          accept;
  logic                          emit;
  logic                          flush_more;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // The center point exists once seen + k reaches h + 1; this covers both
  // the regular point (k = 0) and the flush steps.
  assign emit = ({1'b0, seen_q} + CntW'(k_q)) >= (CntW'(half_i) + CntW'(1));
  assign flush_more = eop_q && (k_q != half_i);

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    k_d     = k_q;
    eop_d   = eop_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.last = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.win_fill  = (seen_q == '0);
          cmd_o.win_shift = (seen_q != '0);
          if (seen_q != tpps_pkg::SEEN_MAX) begin
            seen_d = seen_q + 1'b1;
          end
          k_d     = '0;
          eop_d   = end_of_path_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (emit) begin
          cmd_o.acc_start = 1'b1;
          last_d  = eop_q && (k_q == half_i);
          state_d = ST_ACC;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_ACC: begin
        cmd_o.acc_run = 1'b1;
        if (sts_i.acc_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (flush_more) begin
          k_d = k_q + 1'b1;
          cmd_o.win_dup = 1'b1;
          state_d = ST_CHECK;
        end else begin
          if (eop_q) begin
            seen_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= '0;
      k_q     <= '0;
      eop_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      k_q     <= k_d;
      eop_q   <= eop_d;
      last_q  <= last_d;
    end
  end

  // An accepted word always moves on to the emit check.
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CHECK)
    else $error("accepted word did not reach the emit check");

  // The output register is only loaded when it can take a word.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten");

  // The flush step counter never runs past the half width.
  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> k_q <= half_i)
    else $error("flush counter beyond half width");

  // The end of a path clears the point count.
  a_path_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEXT && eop_q && !flush_more) |=> seen_q == '0)
    else $error("point count not cleared at end of path");

endmodule

>>> design/tpps_dp.sv
// Datapath of the triangular point path smoother.
// Window shift register, weighted tap accumulator, bit-serial divider and
// output register. Depends on tpps_pkg.
module tpps_dp #(
  parameter int MaxHalf = tpps_pkg::MAX_HALF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tpps_pkg::HALF_W-1:0]    half_i,
  input  logic [tpps_pkg::COORD_W-1:0]   point_x_i,
  input  logic [tpps_pkg::COORD_W-1:0]   point_y_i,
  input  tpps_pkg::cmd_t                 cmd_i,
  output tpps_pkg::sts_t                 sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tpps_pkg::COORD_W-1:0]   smooth_x_o,
  output logic [tpps_pkg::COORD_W-1:0]   smooth_y_o,
  output logic                           final_output_o
);

  localparam int CW     = tpps_pkg::COORD_W;
  localparam int WinLen = 2 * MaxHalf + 1;
  localparam int MIdxW  = (WinLen > 1) ? $clog2(WinLen) : 1;
  localparam int WtW    = $clog2(MaxHalf + 2);
  localparam int DMax   = (MaxHalf + 1) * (MaxHalf + 1);
  localparam int DivW   = $clog2(DMax + 1);
  localparam int SumW   = CW + $clog2(DMax);
  localparam int BitW   = $clog2(CW);

  logic [CW-1:0]   win_x_q [WinLen];
  logic [CW-1:0]   win_y_q [WinLen];
  logic [MIdxW-1:0] m_q;
  logic [SumW-1:0] acc_x_q, acc_y_q;
  logic [SumW-1:0] rem_x_q, rem_y_q;
  logic [CW-1:0]   quo_x_q, quo_y_q;
  logic [BitW-1:0] bit_q;
  logic            out_valid_q;
  logic [CW-1:0]   smooth_x_q, smooth_y_q;
  logic            final_q;

  logic [MIdxW-1:0] hh, two_h, tap_dist;
  logic [WtW-1:0]   h1, weight;
  logic [DivW-1:0]  divisor;
  logic [SumW-1:0]  prod_x, prod_y, sum_x, sum_y;
  logic [SumW-1:0]  dsh;
  logic             ge_x, ge_y;

  assign hh    = MIdxW'(half_i);
  assign two_h = hh << 1;
  assign tap_dist = (m_q > hh) ? (m_q - hh) : (hh - m_q);
  assign h1    = WtW'(half_i) + WtW'(1);
  assign weight = h1 - WtW'(tap_dist);
  assign divisor = DivW'(DivW'(h1) * DivW'(h1));

  assign prod_x = SumW'(win_x_q[m_q]) * SumW'(weight);
  assign prod_y = SumW'(win_y_q[m_q]) * SumW'(weight);
  assign sum_x  = acc_x_q + prod_x;
  assign sum_y  = acc_y_q + prod_y;

  // Restoring division: the quotient always fits in a coordinate, so only
  // its low bits are developed, most significant first.
  assign dsh  = SumW'(divisor) << bit_q;
  assign ge_x = rem_x_q >= dsh;
  assign ge_y = rem_y_q >= dsh;

  assign sts_o.acc_done = (m_q == two_h);
  assign sts_o.div_done = (bit_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_fill) begin
      for (int i = 0; i < WinLen; i++) begin
        win_x_q[i] <= point_x_i;
        win_y_q[i] <= point_y_i;
      end
    end else if (cmd_i.win_shift || cmd_i.win_dup) begin
      for (int i = 1; i < WinLen; i++) begin
        win_x_q[i] <= win_x_q[i-1];
        win_y_q[i] <= win_y_q[i-1];
      end
      if (cmd_i.win_shift) begin
        win_x_q[0] <= point_x_i;
        win_y_q[0] <= point_y_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_start) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (cmd_i.acc_run) begin
      acc_x_q <= sum_x;
      acc_y_q <= sum_y;
      if (sts_o.acc_done) begin
        rem_x_q <= sum_x;
        rem_y_q <= sum_y;
        quo_x_q <= '0;
        quo_y_q <= '0;
      end
    end else if (cmd_i.div_run) begin
      if (ge_x) begin
        rem_x_q <= rem_x_q - dsh;
      end
      if (ge_y) begin
        rem_y_q <= rem_y_q - dsh;
      end
      quo_x_q <= {quo_x_q[CW-2:0], ge_x};
      quo_y_q <= {quo_y_q[CW-2:0], ge_y};
    end
    if (cmd_i.out_load) begin
      smooth_x_q <= quo_x_q;
      smooth_y_q <= quo_y_q;
      final_q    <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_start) begin
        m_q <= '0;
      end else if (cmd_i.acc_run) begin
        m_q <= m_q + 1'b1;
        if (sts_o.acc_done) begin
          bit_q <= BitW'(CW - 1);
        end
      end else if (cmd_i.div_run) begin
        bit_q <= bit_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign smooth_x_o     = smooth_x_q;
  assign smooth_y_o     = smooth_y_q;
  assign final_output_o = final_q;

endmodule

>>> design/triangular_point_path_smoother.sv
// Top level of the triangular point path smoother.
// Holds the half width register and joins tpps_ctrl and tpps_dp.
// Depends on tpps_pkg, tpps_ctrl and tpps_dp.
//
// Usage: path points enter on the input channel (in_valid_i / in_stall_o),
// one word per point, the last point of a path flagged by end_of_path_i.
// Smoothed points leave on the output channel (out_valid_o / out_stall_i),
// the last one of a path flagged by final_output_o. Output lags input by
// h points; the final input word releases the remaining h points.
// The half width h is written through cfg_we_i / cfg_data_i while idle.
// One point is worked on at a time. A point that yields a word needs
// 2h + 1 weighted taps through one multiply-add per coordinate and ten
// quotient bits of a serial divider, plus the check, load and step
// states. An end-of-path point adds h flush steps, each of which may
// yield a word.
// Reset clears the controller, the point count and the output valid flag,
// and sets h to 2. A stalled output word holds; the block keeps working
// until the next word needs the output register.
module triangular_point_path_smoother #(
  parameter int MaxHalf = tpps_pkg::MAX_HALF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpps_pkg::HALF_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tpps_pkg::COORD_W-1:0]  point_x_i,
  input  logic [tpps_pkg::COORD_W-1:0]  point_y_i,
  input  logic                          end_of_path_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tpps_pkg::COORD_W-1:0]  smooth_x_o,
  output logic [tpps_pkg::COORD_W-1:0]  smooth_y_o,
  output logic                          final_output_o
);

  logic [tpps_pkg::HALF_W-1:0] half_width_q;
  logic [tpps_pkg::HALF_W-1:0] half_eff;
  tpps_pkg::cmd_t              cmd;
  tpps_pkg::sts_t              sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= tpps_pkg::HALF_RESET;
    end else if (cfg_we_i) begin
      half_width_q <= cfg_data_i;
    end
  end

  // The window only covers MaxHalf points on each side.
  assign half_eff = (half_width_q > tpps_pkg::HALF_W'(MaxHalf)) ?
                    tpps_pkg::HALF_W'(MaxHalf) : half_width_q;

  tpps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_i        (half_eff),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .end_of_path_i (end_of_path_i),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  tpps_dp #(
    .MaxHalf (MaxHalf)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .half_i         (half_eff),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smooth_x_o     (smooth_x_o),
    .smooth_y_o     (smooth_y_o),
    .final_output_o (final_output_o)
  );

endmodule
